FILE: sv/lapg_pkg.sv
// Package for the LFO auto-pan gain block.
// Holds register indexes, waveform codes, sequencer states, fixed constants and
// the elaboration-time builder for the quarter-wave sine table. No dependencies.
package lapg_pkg;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;

    // Width of the shared multiplier's A operand (largest operand is the
    // signed gain difference).
    localparam int MUL_A_W = 34;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PHASE_INC  = 2'd0,
        REG_PAN_WIDTH  = 2'd1,
        REG_WAVE_SHAPE = 2'd2,
        REG_SMOOTHING  = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_TRIANGLE = 2'd1,
        WAVE_SAW      = 2'd2,
        WAVE_SQUARE   = 2'd3
    } wave_t;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_LFO    = 11'b000_0000_0010,
        ST_DIV    = 11'b000_0000_0100,
        ST_THETA  = 11'b000_0000_1000,
        ST_SIN0   = 11'b000_0001_0000,
        ST_SIN1   = 11'b000_0010_0000,
        ST_GAIN   = 11'b000_0100_0000,
        ST_SMUL   = 11'b000_1000_0000,
        ST_SMOOTH = 11'b001_0000_0000,
        ST_OMUL   = 11'b010_0000_0000,
        ST_OUT    = 11'b100_0000_0000
    } state_t;

    localparam logic [31:0] RST_PHASE_INC = 32'd89478;
    localparam logic [7:0]  RST_PAN_WIDTH = 8'd128;
    localparam wave_t       RST_WAVE      = WAVE_SINE;
    localparam logic [15:0] RST_ALPHA     = 16'd171;

    // 65536*255: offset that centers the pan product before the angle divide.
    localparam logic signed [27:0] PAN_OFFSET   = 28'sd16711680;
    // ceil(2^32/255): exact reciprocal for the divide by 255 over 23-bit values.
    localparam logic [24:0]        RECIP_255    = 25'd16843010;
    localparam logic [14:0]        THETA_MAX    = 15'd16384;
    localparam logic [15:0]        QUARTER_TURN = 16'd16384;
    localparam logic [63:0]        HALF_PI_Q30  = 64'd1686629713;

    // Divide by (2k)(2k+1) for the k-th Taylor term.
    function automatic logic [63:0] taylor_div(input logic [63:0] t, input int k);
        logic [63:0] q;
        unique case (k)
            1:       q = t / 64'd6;
            2:       q = t / 64'd20;
            3:       q = t / 64'd42;
            4:       q = t / 64'd72;
            5:       q = t / 64'd110;
            6:       q = t / 64'd156;
            7:       q = t / 64'd210;
            default: q = t;
        endcase
        return q;
    endfunction

    // One entry of the quarter-wave table: round(32768*sin(pi/2*idx/2^bits)),
    // evaluated with an integer Taylor series in Q2.30.
    function automatic logic [15:0] sine_entry(input int unsigned idx,
                                               input int unsigned table_bits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] v;
        int                 k;
        x    = (HALF_PI_Q30 * 64'(idx)) >> table_bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (k = 1; k <= 7; k++) begin
            term = taylor_div((term * x2) >> 30, k);
            if ((k & 1) != 0) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        v = (sum + 64'sd16384) >>> 15;
        if (v > 64'sd32768) begin
            v = 64'sd32768;
        end
        return v[15:0];
    endfunction

endpackage

FILE: sv/lfo_auto_pan_gain.sv
// LFO auto-pan gain: multiplies each mono sample by an LFO-driven, smoothed gain.
// Top level; depends on lapg_pkg, lapg_sin and lapg_mul.
//
// The sequencer steps each accepted sample through the LFO, DIV, THETA, SIN0,
// SIN1, GAIN, SMUL, SMOOTH, OMUL and OUT states, from the transfer on the input
// channel to the result in the output register, and takes no new sample until
// it is back in idle. It steers four products (pan depth, angle reciprocal,
// gain smoothing and output scaling) through the one shared multiplier and
// makes three sine table reads. s_ready is high only while the sequencer is
// idle; a finished result waits in the output register without blocking the
// next input transfer, but the next result holds the sequencer in OUT until
// the waiting one is taken. Configuration writes take effect at once and belong
// to the idle block: the user must keep to this, the block does not enforce it. There is no clearing pass after reset.
module lfo_auto_pan_gain #(
    parameter int PHASE_BITS      = 32,
    parameter int SAMPLE_BITS     = 24,
    parameter int SINE_TABLE_BITS = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [lapg_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [lapg_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [SAMPLE_BITS-1:0]        s_sample_in,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [SAMPLE_BITS-1:0]        m_sample_out
);
    import lapg_pkg::*;

    localparam int MUL_B_W = (SAMPLE_BITS > 26) ? SAMPLE_BITS : 26;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int RES_W   = MUL_P_W - 32;
    localparam logic signed [RES_W-1:0] SAMP_MAX =
        $signed({{(RES_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
    localparam logic signed [RES_W-1:0] SAMP_MIN = ~SAMP_MAX;
    localparam logic signed [MUL_P_W-1:0] ROUND_HALF =
        $signed({{(MUL_P_W-32){1'b0}}, 1'b1, 31'b0});

    state_t state_reg, state_next;

    logic [PHASE_BITS-1:0]         inc_reg;
    logic [7:0]                    pan_reg;
    wave_t                         shape_reg;
    logic [15:0]                   alpha_reg;
    logic [PHASE_BITS-1:0]         phase_reg;
    logic [31:0]                   sg_reg;
    logic [31:0]                   sg_next;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic [14:0]                   theta_reg;
    logic [14:0]                   theta_next;
    logic signed [16:0]            cos_reg;
    logic signed [33:0]            d_reg;
    logic signed [33:0]            d_next;
    logic                          m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] m_sample_out_reg;
    logic signed [SAMPLE_BITS-1:0] sample_next;
    logic                          out_load;

    logic [15:0]                   sin_angle;
    logic signed [16:0]            sin_val;
    logic                          mul_en;
    logic signed [MUL_A_W-1:0]     mul_a;
    logic signed [MUL_B_W-1:0]     mul_b;
    logic signed [MUL_P_W-1:0]     product;

    logic [15:0]                   ph;
    logic [16:0]                   tri_base;
    logic signed [17:0]            lfo;
    logic signed [18:0]            pan_b;
    logic signed [27:0]            num;
    logic [22:0]                   num_div8;
    logic signed [17:0]            gain_sum;
    logic [16:0]                   gain;
    logic signed [33:0]            smooth_step;
    logic signed [35:0]            smooth_sum;
    logic signed [MUL_P_W-1:0]     rounded;
    logic signed [RES_W-1:0]       res;

    lapg_sin #(
        .TABLE_BITS(SINE_TABLE_BITS)
    ) u_sin (
        .aclk   (aclk),
        .angle  (sin_angle),
        .sin_val(sin_val)
    );

    lapg_mul #(
        .A_W(MUL_A_W),
        .B_W(MUL_B_W)
    ) u_mul (
        .aclk   (aclk),
        .en     (mul_en),
        .op_a   (mul_a),
        .op_b   (mul_b),
        .product(product)
    );

    // The input side stays closed while reset is held.
    assign s_ready      = aresetn && (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_out_reg;
    assign out_load     = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // LFO value in Q0.16, 0 to 65536.
    assign ph       = phase_reg[PHASE_BITS-1 -: 16];
    assign tri_base = ph[15] ? (17'h10000 - {1'b0, ph}) : {1'b0, ph};

    always_comb begin
        unique case (shape_reg)
            WAVE_SINE:     lfo = 18'sd32768 + {sin_val[16], sin_val};
            WAVE_TRIANGLE: lfo = $signed({tri_base, 1'b0});
            WAVE_SAW:      lfo = $signed({2'b00, ph});
            WAVE_SQUARE:   lfo = ph[15] ? 18'sd0 : 18'sd65536;
            default:       lfo = 18'sd0;
        endcase
    end

    assign pan_b = $signed({lfo, 1'b0}) - 19'sd65536;

    // Angle numerator; the divide by 2040 is a shift by 3 and a divide by 255.
    always_comb begin
        num = $signed(product[27:0]) + PAN_OFFSET;
        if (num < 0) begin
            num = 28'sd0;
        end
    end
    assign num_div8 = num[25:3];

    assign theta_next = (product[46:32] > THETA_MAX) ? THETA_MAX : product[46:32];

    // Raw gain is cos + sin of the pan angle; the difference feeds the filter.
    assign gain_sum = {cos_reg[16], cos_reg} + {sin_val[16], sin_val};
    assign gain     = gain_sum[17] ? 17'd0 : gain_sum[16:0];
    assign d_next   = $signed({1'b0, gain, 16'b0}) - $signed({2'b00, sg_reg});

    assign smooth_step = product[49:16];
    assign smooth_sum  = $signed({4'b0000, sg_reg}) + 36'(smooth_step);

    always_comb begin
        if (smooth_sum < 0) begin
            sg_next = 32'd0;
        end else if (smooth_sum > 36'sh0FFFFFFFF) begin
            sg_next = 32'hFFFF_FFFF;
        end else begin
            sg_next = smooth_sum[31:0];
        end
    end

    assign rounded = product + ROUND_HALF;
    assign res     = rounded[MUL_P_W-1:32];

    always_comb begin
        if (res > SAMP_MAX) begin
            sample_next = SAMP_MAX[SAMPLE_BITS-1:0];
        end else if (res < SAMP_MIN) begin
            sample_next = SAMP_MIN[SAMPLE_BITS-1:0];
        end else begin
            sample_next = res[SAMPLE_BITS-1:0];
        end
    end

    // Operand steering for the shared multiplier and the sine table.
    always_comb begin
        mul_en    = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        sin_angle = ph;
        unique case (state_reg)
            ST_LFO: begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(pan_b);
                mul_b  = $signed(MUL_B_W'(pan_reg));
            end
            ST_DIV: begin
                mul_en = 1'b1;
                mul_a  = $signed(MUL_A_W'(num_div8));
                mul_b  = $signed(MUL_B_W'(RECIP_255));
            end
            ST_SIN0: sin_angle = {1'b0, theta_reg} + QUARTER_TURN;
            ST_SIN1: sin_angle = {1'b0, theta_reg};
            ST_SMUL: begin
                mul_en = 1'b1;
                mul_a  = d_reg;
                mul_b  = $signed(MUL_B_W'(alpha_reg));
            end
            ST_OMUL: begin
                mul_en = 1'b1;
                mul_a  = $signed({2'b00, sg_reg});
                mul_b  = MUL_B_W'(x_reg);
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_LFO;
            ST_LFO:    state_next = ST_DIV;
            ST_DIV:    state_next = ST_THETA;
            ST_THETA:  state_next = ST_SIN0;
            ST_SIN0:   state_next = ST_SIN1;
            ST_SIN1:   state_next = ST_GAIN;
            ST_GAIN:   state_next = ST_SMUL;
            ST_SMUL:   state_next = ST_SMOOTH;
            ST_SMOOTH: state_next = ST_OMUL;
            ST_OMUL:   state_next = ST_OUT;
            ST_OUT:    if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            inc_reg     <= PHASE_BITS'(RST_PHASE_INC);
            pan_reg     <= RST_PAN_WIDTH;
            shape_reg   <= RST_WAVE;
            alpha_reg   <= RST_ALPHA;
            phase_reg   <= '0;
            sg_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_PHASE_INC:  inc_reg   <= cfg_wdata[PHASE_BITS-1:0];
                    REG_PAN_WIDTH:  pan_reg   <= cfg_wdata[7:0];
                    REG_WAVE_SHAPE: shape_reg <= wave_t'(cfg_wdata[1:0]);
                    REG_SMOOTHING:  alpha_reg <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_SMOOTH) begin
                sg_reg <= sg_next;
            end
            // The phase advances only once the sample's result is handed over.
            if (out_load) begin
                phase_reg   <= phase_reg + inc_reg;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            x_reg <= s_sample_in;
        end
        if (state_reg == ST_THETA) begin
            theta_reg <= theta_next;
        end
        if (state_reg == ST_SIN1) begin
            cos_reg <= sin_val;
        end
        if (state_reg == ST_GAIN) begin
            d_reg <= d_next;
        end
        if (out_load) begin
            m_sample_out_reg <= sample_next;
        end
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_LFO))
        else $error("input transfer did not start the sequencer");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result appeared outside the output step");

    a_phase_on_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$stable(phase_reg)) |-> $past(out_load))
        else $error("LFO phase moved without a delivered result");

    a_gain_on_smooth: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$stable(sg_reg)) |-> $past(state_reg == ST_SMOOTH))
        else $error("smoothed gain changed outside the filter step");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && m_valid_reg && !m_ready) |=> (state_reg == ST_OUT))
        else $error("sequencer left the output step while the result was blocked");

endmodule

FILE: sv/lapg_sin.sv
// Sine lookup for the LFO auto-pan gain block: quarter-wave table with
// quadrant folding and a registered read. Depends on lapg_pkg.
module lapg_sin #(
    parameter int TABLE_BITS = 8
) (
    input  logic               aclk,
    input  logic [15:0]        angle,
    output logic signed [16:0] sin_val
);
    import lapg_pkg::*;

    localparam int TAB_N = 1 << TABLE_BITS;
    localparam int IDX_W = TABLE_BITS + 1;

    logic [15:0]           rom [0:TAB_N];
    logic [TABLE_BITS-1:0] frac;
    logic [IDX_W-1:0]      idx;
    logic [15:0]           mag_reg;
    logic                  neg_reg;

    for (genvar g = 0; g <= TAB_N; g++) begin : g_rom
        assign rom[g] = sine_entry(g, TABLE_BITS);
    end

    // Odd quadrants read the table backwards; the lookup truncates.
    assign frac = angle[13 -: TABLE_BITS];
    assign idx  = angle[14] ? (IDX_W'(TAB_N) - {1'b0, frac}) : {1'b0, frac};

    always_ff @(posedge aclk) begin
        mag_reg <= rom[idx];
        neg_reg <= angle[15];
    end

    assign sin_val = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});

endmodule

FILE: sv/lapg_mul.sv
// Shared signed multiplier with a registered product for the LFO auto-pan
// gain block. No package dependencies.
module lapg_mul #(
    parameter int A_W = 34,
    parameter int B_W = 26
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [A_W-1:0]    op_a,
    input  logic signed [B_W-1:0]    op_b,
    output logic signed [A_W+B_W-1:0] product
);
    logic signed [A_W+B_W-1:0] product_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            product_reg <= op_a * op_b;
        end
    end

    assign product = product_reg;

endmodule
